### sv/sorted_list_insert_defines.svh
// Assertion macros used by the sorted list insert RTL.
`ifndef SORTED_LIST_INSERT_DEFINES_SVH
`define SORTED_LIST_INSERT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/sli_pkg.sv
// Package with the types, widths and codes of the sorted list insert block.
package sli_pkg;

	localparam int DEFAULT_DEPTH = 16;

	localparam int VALUE_W  = 32;
	localparam int KIND_W   = 2;
	localparam int INDEX_W  = 4;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

	localparam logic REG_DESCENDING = 1'b0;
	localparam logic REG_UNUSED     = 1'b1;

	typedef struct packed {
		logic                      ins;
		logic                      desc;
		logic signed [VALUE_W-1:0] value;
	} sli_bcast_t;

endpackage

### sv/sli_cell.sv
// One cell of the sorted list: holds one entry and shifts it along on an insert.
module sli_cell
	import sli_pkg::*;
(
	input  logic                      clk,
	input  sli_bcast_t                bcast,
	input  logic                      valid,
	input  logic                      found_in,
	input  logic signed [VALUE_W-1:0] left_entry,
	output logic                      found_out,
	output logic                      hit,
	output logic signed [VALUE_W-1:0] entry
);

	logic signed [VALUE_W-1:0] entry_q;
	logic                      after_w;
	logic                      match_w;

	assign after_w   = bcast.desc ? (entry_q < bcast.value) : (entry_q > bcast.value);
	assign match_w   = !valid || after_w;
	assign hit       = match_w && !found_in;
	assign found_out = found_in || match_w;
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (bcast.ins) begin
			if (found_in) begin
				entry_q <= left_entry;
			end else if (match_w) begin
				entry_q <= bcast.value;
			end
		end
	end

endmodule

### sv/sorted_list_insert.sv
// Top level of the sorted list insert block: cell row, control and ports.
// The block keeps up to DEPTH signed 32-bit values in ascending order, or in
// descending order when the descending register is set. Each cell of the row
// compares its entry with the incoming value at once and the whole row shifts
// in the same clock, so one word is taken per cycle unless the output stalls,
// and its result word is presented from the output register on the following
// cycle. A value equal to existing entries lands after them. Reads address the
// first sixteen entries, a full list rejects an insert, a clear only resets the count.
module sorted_list_insert
	import sli_pkg::*;
#(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // value, index, zero padding
	input  logic [KIND_W-1:0]     s_tuser,  // kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,  // position, read_data, count, zero padding
	output logic [STATUS_W-1:0]   m_tuser,  // status
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready
);

	`include "sorted_list_insert_defines.svh"

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int PW   = $clog2(DEPTH);
	localparam int NIDX = 2 ** INDEX_W;
	localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
	localparam int PXW  = (PW > POS_W) ? PW : POS_W;
	localparam int CXW  = (CW > COUNT_W) ? CW : COUNT_W;

	logic                      desc_q;
	logic [CW-1:0]             count_q;
	logic                      out_valid_q;
	logic [POS_W-1:0]          pos_q;
	logic signed [VALUE_W-1:0] rdata_q;
	logic [COUNT_W-1:0]        ocount_q;
	logic [STATUS_W-1:0]       status_q;

	logic                      acc_w;
	logic [KIND_W-1:0]         kind_w;
	logic signed [VALUE_W-1:0] value_w;
	logic [INDEX_W-1:0]        index_w;
	logic                      full_w;
	logic                      rd_ok_w;
	sli_bcast_t                bcast_w;

	logic [DEPTH-1:0]          valid_w;
	logic [DEPTH-1:0]          found_w;
	logic [DEPTH-1:0]          hit_w;
	logic signed [VALUE_W-1:0] entry_w [DEPTH];
	logic signed [VALUE_W-1:0] rd_tab_w [NIDX];

	logic [PW-1:0]             pos_w;
	logic [PXW-1:0]            pos_x_w;
	logic [CW-1:0]             count_nxt_w;
	logic [CXW-1:0]            count_x_w;
	logic [POS_W-1:0]          pos_nxt_w;
	logic signed [VALUE_W-1:0] rdata_nxt_w;
	logic [STATUS_W-1:0]       status_nxt_w;

	assign kind_w  = s_tuser;
	assign value_w = s_tdata[VALUE_W-1:0];
	assign index_w = s_tdata[VALUE_W+INDEX_W-1:VALUE_W];

	assign s_tready = !out_valid_q || m_tready;
	assign acc_w    = s_tvalid && s_tready;
	assign full_w   = (count_q == CW'(DEPTH));
	assign rd_ok_w  = (CMPW'(index_w) < CMPW'(count_q));

	assign bcast_w.ins   = acc_w && (kind_w == KIND_INSERT) && !full_w;
	assign bcast_w.desc  = desc_q;
	assign bcast_w.value = value_w;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                      found_in_w;
		logic signed [VALUE_W-1:0] left_w;

		assign valid_w[i] = (count_q > CW'(i));
		if (i == 0) begin : g_head
			assign found_in_w = 1'b0;
			assign left_w     = '0;
		end else begin : g_body
			assign found_in_w = found_w[i-1];
			assign left_w     = entry_w[i-1];
		end

		sli_cell u_cell (
			.clk        (clk),
			.bcast      (bcast_w),
			.valid      (valid_w[i]),
			.found_in   (found_in_w),
			.left_entry (left_w),
			.found_out  (found_w[i]),
			.hit        (hit_w[i]),
			.entry      (entry_w[i])
		);
	end

	for (genvar j = 0; j < NIDX; j++) begin : g_rd
		if (j < DEPTH) begin : g_live
			assign rd_tab_w[j] = entry_w[j];
		end else begin : g_none
			assign rd_tab_w[j] = '0;
		end
	end

	always_comb begin
		pos_w = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pos_w = pos_w | (hit_w[i] ? PW'(i) : PW'(0));
		end
	end

	assign pos_x_w = PXW'(pos_w);

	always_comb begin
		count_nxt_w  = count_q;
		pos_nxt_w    = '0;
		rdata_nxt_w  = '0;
		status_nxt_w = STATUS_OK;
		case (kind_w)
			KIND_INSERT: begin
				if (full_w) begin
					status_nxt_w = STATUS_FULL;
				end else begin
					count_nxt_w = count_q + 1'b1;
					pos_nxt_w   = pos_x_w[POS_W-1:0];
				end
			end
			KIND_READ: begin
				if (rd_ok_w) begin
					rdata_nxt_w = rd_tab_w[index_w];
				end else begin
					status_nxt_w = STATUS_BAD_INDEX;
				end
			end
			KIND_CLEAR: begin
				count_nxt_w = '0;
			end
			default: begin
			end
		endcase
	end

	assign count_x_w = CXW'(count_nxt_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc_w) begin
				count_q     <= count_nxt_w;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_w) begin
			pos_q    <= pos_nxt_w;
			rdata_q  <= rdata_nxt_w;
			ocount_q <= count_x_w[COUNT_W-1:0];
			status_q <= status_nxt_w;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W - POS_W - VALUE_W - COUNT_W){1'b0}},
		ocount_q, rdata_q, pos_q};
	assign m_tuser  = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_DESCENDING) begin
				desc_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DESCENDING: prdata = {{(APB_DW - 1){1'b0}}, desc_q};
			REG_UNUSED:     prdata = '0;
			default:        prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	`SLI_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH),
		"List count exceeds its depth.")
	`SLI_ASSERT_IMP(a_one_slot, clk, arst_n, bcast_w.ins, $onehot(hit_w),
		"An insert must select exactly one cell.")
	`SLI_ASSERT_NXT(a_insert_grows, clk, arst_n, bcast_w.ins,
		count_q == $past(count_q) + 1'b1, "An accepted insert did not grow the list.")
	`SLI_ASSERT_NXT(a_clear_empties, clk, arst_n, acc_w && (kind_w == KIND_CLEAR),
		count_q == '0, "A clear did not empty the list.")
	`SLI_ASSERT_NXT(a_result_shown, clk, arst_n, acc_w, m_tvalid,
		"An accepted word produced no result word.")

endmodule
